FILE: rtl/core/bvc_pkg.sv
// Shared types, constants and helper functions for the balance and velocity controller.
`default_nettype none

package bvc_pkg;

  // Datapath widths of the shared arithmetic unit.
  localparam int unsigned OP_W     = 66;
  localparam int unsigned DIVR_W   = 48;
  localparam int unsigned MUL_BITS = 32;
  localparam int unsigned CNT_W    = 7;

  // Angle handling, in millidegrees.
  localparam logic [16:0] QUARTER   = 17'd90000;
  localparam logic [18:0] HALF_TURN = 19'd180000;
  localparam logic [18:0] THREE_Q   = 19'd270000;
  localparam logic [19:0] FULL_TURN = 20'd360000;

  // Sine series constants (Q2.30).
  localparam logic [31:0] PI_Q30     = 32'd3373259426;
  localparam logic [31:0] ONE_Q30    = 32'h4000_0000;
  localparam logic [65:0] X_ROUND    = 66'd90000;
  localparam logic [47:0] X_DIV      = 48'd180000;
  localparam int unsigned SINE_TERMS = 5;

  // Scaling constants of the two control terms.
  localparam logic [47:0] BAL_SCALE       = 48'd15625;
  localparam logic [47:0] MILLI           = 48'd1000;
  localparam logic [9:0]  FILTER_MAX      = 10'd1000;
  localparam logic [47:0] VEL_DIV         = 48'd256000;
  localparam int          INTEGRAL_LIMIT  = 10000;
  localparam int          SPEED_FRAC_BITS = 8;

  typedef enum logic [2:0] {
    REG_ANGLE_OFFSET  = 3'd0,
    REG_TILT_GAIN     = 3'd1,
    REG_RATE_GAIN     = 3'd2,
    REG_FILTER_FACTOR = 3'd3,
    REG_SPEED_GAIN    = 3'd4,
    REG_POSITION_GAIN = 3'd5
  } cfg_reg_t;

  typedef enum logic {
    OP_MUL,
    OP_DIV
  } unit_op_t;

  typedef struct packed {
    logic     start;
    unit_op_t op;
  } unit_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WRAP,
    ST_QUAD,
    ST_ISSUE,
    ST_WAIT,
    ST_DONE
  } state_t;

  typedef enum logic [4:0] {
    SIN_PI,
    SIN_X,
    SIN_SQ,
    SIN_TM,
    SIN_TD,
    SIN_XT,
    BAL_KS,
    BAL_KSC,
    BAL_N1,
    BAL_RK,
    BAL_CC,
    BAL_DEN,
    BAL_DIV,
    VEL_FF,
    VEL_FS,
    VEL_FD,
    VEL_FK,
    VEL_FKM,
    VEL_IK,
    VEL_DIV_STEP
  } step_t;

  // Divisors of the nested sine series, innermost term first.
  function automatic logic [47:0] sine_div(input logic [2:0] k);
    logic [47:0] d;
    case (k)
      3'd0:    d = 48'd110;
      3'd1:    d = 48'd72;
      3'd2:    d = 48'd42;
      3'd3:    d = 48'd20;
      default: d = 48'd6;
    endcase
    return d;
  endfunction

  // Conditional two's complement negation.
  function automatic logic [65:0] cneg(input logic [65:0] v, input logic neg);
    return (v ^ {66{neg}}) + 66'(neg);
  endfunction

  // Saturates a sign and magnitude value to 16-bit signed.
  function automatic logic [15:0] sat_mag(input logic [65:0] q, input logic neg);
    logic [15:0] r;
    if (!neg) begin
      r = (q > 66'd32767) ? 16'h7fff : q[15:0];
    end else begin
      r = (q > 66'd32768) ? 16'h8000 : 16'(~q[15:0] + 16'd1);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/balance_velocity_controller.sv
// Top level of the balance and velocity controller for a two-wheeled robot.
//
// Each input transfer is one control tick: tilt angle and rate plus the two
// wheel encoder counts. The block answers every tick with one output transfer
// holding the balance term, the velocity term and drive = balance - velocity,
// each saturated to 16-bit signed. Both channels use valid and stall.
// The configuration channel writes one of six registers per transfer; it is
// always ready and must only be used while the block is idle.
// The work of a tick is 27 multiplications and 15 divisions on a single
// bit-serial multiply/divide unit, plus sequencing. One tick is processed at
// a time. A finished result sits in the output register; the next tick is
// accepted while it waits. If the receiver stalls long enough that a second
// result is ready, the block holds it until the output register frees.
// Reset clears the configuration registers, the filtered speed and the speed
// integral, and leaves the block idle with no result pending.
`default_nettype none

module balance_velocity_controller #(
  parameter int INTEGRAL_LIMIT = bvc_pkg::INTEGRAL_LIMIT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [18:0] tilt_angle,
  input  logic signed [21:0] tilt_rate,
  input  logic signed [15:0] left_count,
  input  logic signed [15:0] right_count,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] drive,
  output logic signed [15:0] balance_term,
  output logic signed [15:0] velocity_term,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  localparam logic signed [32:0] INT_LIM =
    33'(INTEGRAL_LIMIT * (2 ** bvc_pkg::SPEED_FRAC_BITS));

  // Sequencer state.
  bvc_pkg::state_t state;
  bvc_pkg::state_t state_next;
  bvc_pkg::step_t  step;
  bvc_pkg::step_t  step_next;
  logic [2:0]      k;
  logic            pass;

  // Configuration registers.
  logic [15:0] angle_offset;
  logic [15:0] tilt_gain;
  logic [15:0] rate_gain;
  logic [9:0]  filter_factor;
  logic [15:0] speed_gain;
  logic [15:0] position_gain;

  // Controller state carried between ticks.
  logic signed [31:0] filtered;
  logic signed [31:0] speed_integral;

  // Working registers of one tick.
  logic [19:0] angle_err;
  logic [21:0] rate_in;
  logic [16:0] sum_cnt;
  logic [18:0] turn;
  logic [1:0]  quadrant;
  logic [16:0] quad_rem;
  logic [16:0] sin_arg;
  logic [31:0] x;
  logic [31:0] x2;
  logic [31:0] t;
  logic [65:0] acc;
  logic [65:0] num;
  logic [47:0] den;
  logic [14:0] s_mag;
  logic        s_neg;
  logic [14:0] c_mag;
  logic [15:0] bal;
  logic [15:0] vel;

  // Shared unit interface.
  bvc_pkg::unit_req_t  unit_req;
  bvc_pkg::unit_stat_t unit_stat;
  bvc_pkg::unit_op_t   issue_op;
  logic                issue_start;
  logic [65:0]         unit_a;
  logic [47:0]         unit_b;
  logic [65:0]         res;
  logic                wb;
  logic                out_load;

  // Combinational helpers.
  logic [1:0]         q_c;
  logic [16:0]        rem_c;
  logic [9:0]         f_eff;
  logic [21:0]        rate_abs;
  logic [31:0]        filt_abs;
  logic [31:0]        integ_abs;
  logic [16:0]        sum_abs;
  logic [65:0]        num_abs;
  logic [32:0]        rnd;
  logic [17:0]        mag_full;
  logic [14:0]        mag;
  logic signed [32:0] isum;
  logic [16:0]        dif;

  assign cfg_ready = 1'b1;

  // Quadrant of the wrapped angle error and the remainder within it.
  always_comb begin
    if (turn >= bvc_pkg::THREE_Q) begin
      q_c   = 2'd3;
      rem_c = 17'(turn - bvc_pkg::THREE_Q);
    end else if (turn >= bvc_pkg::HALF_TURN) begin
      q_c   = 2'd2;
      rem_c = 17'(turn - bvc_pkg::HALF_TURN);
    end else if (turn >= {2'b00, bvc_pkg::QUARTER}) begin
      q_c   = 2'd1;
      rem_c = 17'(turn - {2'b00, bvc_pkg::QUARTER});
    end else begin
      q_c   = 2'd0;
      rem_c = turn[16:0];
    end
  end

  assign f_eff     = (filter_factor > bvc_pkg::FILTER_MAX) ? bvc_pkg::FILTER_MAX : filter_factor;
  assign rate_abs  = rate_in[21] ? 22'(-rate_in) : rate_in;
  assign filt_abs  = filtered[31] ? 32'(-filtered) : 32'(filtered);
  assign integ_abs = speed_integral[31] ? 32'(-speed_integral) : 32'(speed_integral);
  assign sum_abs   = sum_cnt[16] ? 17'(-sum_cnt) : sum_cnt;
  assign num_abs   = num[65] ? 66'(-num) : num;

  // Operands of the step that is about to start on the shared unit.
  always_comb begin
    issue_op = bvc_pkg::OP_MUL;
    unit_a   = acc;
    unit_b   = '0;
    case (step)
      bvc_pkg::SIN_PI: begin
        unit_a = 66'(sin_arg);
        unit_b = 48'(bvc_pkg::PI_Q30);
      end
      bvc_pkg::SIN_X: begin
        issue_op = bvc_pkg::OP_DIV;
        unit_b   = bvc_pkg::X_DIV;
      end
      bvc_pkg::SIN_SQ: begin
        unit_a = 66'(x);
        unit_b = 48'(x);
      end
      bvc_pkg::SIN_TM: begin
        unit_a = 66'(x2);
        unit_b = 48'(t);
      end
      bvc_pkg::SIN_TD: begin
        issue_op = bvc_pkg::OP_DIV;
        unit_b   = bvc_pkg::sine_div(k);
      end
      bvc_pkg::SIN_XT: begin
        unit_a = 66'(x);
        unit_b = 48'(t);
      end
      bvc_pkg::BAL_KS: begin
        unit_a = 66'(tilt_gain);
        unit_b = 48'(s_mag);
      end
      bvc_pkg::BAL_KSC: begin
        unit_b = 48'(c_mag);
      end
      bvc_pkg::BAL_N1: begin
        unit_b = bvc_pkg::BAL_SCALE;
      end
      bvc_pkg::BAL_RK: begin
        unit_a = 66'(rate_abs);
        unit_b = 48'(rate_gain);
      end
      bvc_pkg::BAL_CC: begin
        unit_a = 66'(c_mag);
        unit_b = 48'(c_mag);
      end
      bvc_pkg::BAL_DEN: begin
        unit_b = bvc_pkg::BAL_SCALE;
      end
      bvc_pkg::BAL_DIV: begin
        issue_op = bvc_pkg::OP_DIV;
        unit_a   = num_abs;
        unit_b   = den;
      end
      bvc_pkg::VEL_FF: begin
        unit_a = 66'(filt_abs);
        unit_b = 48'(f_eff);
      end
      bvc_pkg::VEL_FS: begin
        unit_a = 66'(sum_abs);
        unit_b = 48'(bvc_pkg::FILTER_MAX - f_eff);
      end
      bvc_pkg::VEL_FD: begin
        issue_op = bvc_pkg::OP_DIV;
        unit_a   = num_abs;
        unit_b   = bvc_pkg::MILLI;
      end
      bvc_pkg::VEL_FK: begin
        unit_a = 66'(filt_abs);
        unit_b = 48'(speed_gain);
      end
      bvc_pkg::VEL_FKM: begin
        unit_b = bvc_pkg::MILLI;
      end
      bvc_pkg::VEL_IK: begin
        unit_a = 66'(integ_abs);
        unit_b = 48'(position_gain);
      end
      bvc_pkg::VEL_DIV_STEP: begin
        issue_op = bvc_pkg::OP_DIV;
        unit_a   = num_abs;
        unit_b   = bvc_pkg::VEL_DIV;
      end
      default: begin
        issue_op = bvc_pkg::OP_MUL;
      end
    endcase
  end

  assign unit_req = '{start: issue_start, op: issue_op};

  bvc_muldiv u_muldiv (
    .clk    (clk),
    .rst    (rst),
    .req    (unit_req),
    .a      (unit_a),
    .b      (unit_b),
    .stat   (unit_stat),
    .result (res)
  );

  assign wb = (state == bvc_pkg::ST_WAIT) && unit_stat.done;

  // Order of the steps; the sine runs twice and its series loops five times.
  always_comb begin
    case (step)
      bvc_pkg::SIN_PI:  step_next = bvc_pkg::SIN_X;
      bvc_pkg::SIN_X:   step_next = bvc_pkg::SIN_SQ;
      bvc_pkg::SIN_SQ:  step_next = bvc_pkg::SIN_TM;
      bvc_pkg::SIN_TM:  step_next = bvc_pkg::SIN_TD;
      bvc_pkg::SIN_TD:  step_next = (k == 3'(bvc_pkg::SINE_TERMS - 1)) ?
                                    bvc_pkg::SIN_XT : bvc_pkg::SIN_TM;
      bvc_pkg::SIN_XT:  step_next = pass ? bvc_pkg::BAL_KS : bvc_pkg::SIN_PI;
      bvc_pkg::BAL_KS:  step_next = bvc_pkg::BAL_KSC;
      bvc_pkg::BAL_KSC: step_next = bvc_pkg::BAL_N1;
      bvc_pkg::BAL_N1:  step_next = bvc_pkg::BAL_RK;
      bvc_pkg::BAL_RK:  step_next = bvc_pkg::BAL_CC;
      bvc_pkg::BAL_CC:  step_next = bvc_pkg::BAL_DEN;
      bvc_pkg::BAL_DEN: step_next = bvc_pkg::BAL_DIV;
      bvc_pkg::BAL_DIV: step_next = bvc_pkg::VEL_FF;
      bvc_pkg::VEL_FF:  step_next = bvc_pkg::VEL_FS;
      bvc_pkg::VEL_FS:  step_next = bvc_pkg::VEL_FD;
      bvc_pkg::VEL_FD:  step_next = bvc_pkg::VEL_FK;
      bvc_pkg::VEL_FK:  step_next = bvc_pkg::VEL_FKM;
      bvc_pkg::VEL_FKM: step_next = bvc_pkg::VEL_IK;
      bvc_pkg::VEL_IK:  step_next = bvc_pkg::VEL_DIV_STEP;
      default:          step_next = bvc_pkg::VEL_DIV_STEP;
    endcase
  end

  // Main state machine: next state.
  always_comb begin
    state_next = state;
    case (state)
      bvc_pkg::ST_IDLE:  if (in_valid) state_next = bvc_pkg::ST_WRAP;
      bvc_pkg::ST_WRAP:  state_next = bvc_pkg::ST_QUAD;
      bvc_pkg::ST_QUAD:  state_next = bvc_pkg::ST_ISSUE;
      bvc_pkg::ST_ISSUE: state_next = bvc_pkg::ST_WAIT;
      bvc_pkg::ST_WAIT: begin
        if (unit_stat.done) begin
          state_next = (step == bvc_pkg::VEL_DIV_STEP) ? bvc_pkg::ST_DONE : bvc_pkg::ST_ISSUE;
        end
      end
      bvc_pkg::ST_DONE:  if (!(out_valid && out_stall)) state_next = bvc_pkg::ST_IDLE;
      default:           state_next = bvc_pkg::ST_IDLE;
    endcase
  end

  // Main state machine: outputs.
  always_comb begin
    in_stall    = 1'b1;
    issue_start = 1'b0;
    out_load    = 1'b0;
    case (state)
      bvc_pkg::ST_IDLE:  in_stall = 1'b0;
      bvc_pkg::ST_ISSUE: issue_start = 1'b1;
      bvc_pkg::ST_DONE:  out_load = !(out_valid && out_stall);
      default:           in_stall = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= bvc_pkg::ST_IDLE;
      step      <= bvc_pkg::SIN_PI;
      k         <= '0;
      pass      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == bvc_pkg::ST_QUAD) begin
        step <= bvc_pkg::SIN_PI;
        pass <= 1'b0;
      end else if (wb) begin
        step <= step_next;
        if (step == bvc_pkg::SIN_SQ) k <= '0;
        if (step == bvc_pkg::SIN_TD) k <= k + 3'd1;
        if (step == bvc_pkg::SIN_XT) pass <= 1'b1;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Configuration registers and the speed state that persists across ticks.
  assign isum = {speed_integral[31], speed_integral} + {filtered[31], filtered};

  always_ff @(posedge clk) begin
    if (rst) begin
      angle_offset   <= '0;
      tilt_gain      <= '0;
      rate_gain      <= '0;
      filter_factor  <= '0;
      speed_gain     <= '0;
      position_gain  <= '0;
      filtered       <= '0;
      speed_integral <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (bvc_pkg::cfg_reg_t'(cfg_index))
          bvc_pkg::REG_ANGLE_OFFSET:  angle_offset  <= cfg_data;
          bvc_pkg::REG_TILT_GAIN:     tilt_gain     <= cfg_data;
          bvc_pkg::REG_RATE_GAIN:     rate_gain     <= cfg_data;
          bvc_pkg::REG_FILTER_FACTOR: filter_factor <= cfg_data[9:0];
          bvc_pkg::REG_SPEED_GAIN:    speed_gain    <= cfg_data;
          bvc_pkg::REG_POSITION_GAIN: position_gain <= cfg_data;
          default:                    ;
        endcase
      end
      if (wb && step == bvc_pkg::VEL_FD) begin
        filtered <= num[65] ? 32'(-res[31:0]) : res[31:0];
      end
      // The integral is updated once the new filtered speed is in place.
      if (wb && step == bvc_pkg::VEL_FK) begin
        if (isum > INT_LIM) begin
          speed_integral <= INT_LIM[31:0];
        end else if (isum < -INT_LIM) begin
          speed_integral <= 32'(-INT_LIM);
        end else begin
          speed_integral <= isum[31:0];
        end
      end
    end
  end

  // Rounding of the series result to Q1.15, capped just below one.
  assign rnd      = {1'b0, res[61:30]} + 33'd16384;
  assign mag_full = rnd[32:15];
  assign mag      = (mag_full > 18'd32767) ? 15'h7fff : mag_full[14:0];

  // Datapath registers of one tick.
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      angle_err <= {tilt_angle[18], tilt_angle} - {{4{angle_offset[15]}}, angle_offset};
      rate_in   <= tilt_rate;
      sum_cnt   <= {left_count[15], left_count} + {right_count[15], right_count};
    end
    if (state == bvc_pkg::ST_WRAP) begin
      turn <= angle_err[19] ? 19'(angle_err + bvc_pkg::FULL_TURN) : angle_err[18:0];
    end
    if (state == bvc_pkg::ST_QUAD) begin
      quadrant <= q_c;
      quad_rem <= rem_c;
      sin_arg  <= q_c[0] ? 17'(bvc_pkg::QUARTER - rem_c) : rem_c;
    end
    if (wb) begin
      case (step)
        bvc_pkg::SIN_PI:  acc <= res + bvc_pkg::X_ROUND;
        bvc_pkg::SIN_X:   x <= res[31:0];
        bvc_pkg::SIN_SQ: begin
          x2 <= res[61:30];
          t  <= bvc_pkg::ONE_Q30;
        end
        bvc_pkg::SIN_TM:  acc <= {30'b0, res[65:30]};
        bvc_pkg::SIN_TD:  t <= 32'(bvc_pkg::ONE_Q30 - res[31:0]);
        bvc_pkg::SIN_XT: begin
          if (!pass) begin
            s_mag   <= mag;
            s_neg   <= quadrant[1];
            sin_arg <= quadrant[0] ? quad_rem : 17'(bvc_pkg::QUARTER - quad_rem);
          end else begin
            // A cosine of zero or below is floored at one LSB.
            c_mag <= ((quadrant[0] ^ quadrant[1]) || mag == 15'd0) ? 15'd1 : mag;
          end
        end
        bvc_pkg::BAL_KS:  acc <= res;
        bvc_pkg::BAL_KSC: acc <= res;
        bvc_pkg::BAL_N1:  num <= bvc_pkg::cneg(res, s_neg);
        bvc_pkg::BAL_RK:  num <= num + bvc_pkg::cneg({res[41:0], 24'b0}, rate_in[21]);
        bvc_pkg::BAL_CC:  acc <= res;
        bvc_pkg::BAL_DEN: den <= res[47:0];
        bvc_pkg::BAL_DIV: bal <= bvc_pkg::sat_mag(res, num[65]);
        bvc_pkg::VEL_FF:  num <= bvc_pkg::cneg(res, filtered[31]);
        bvc_pkg::VEL_FS:  num <= num + bvc_pkg::cneg({res[57:0], 8'b0}, sum_cnt[16]);
        bvc_pkg::VEL_FK:  acc <= res;
        bvc_pkg::VEL_FKM: num <= bvc_pkg::cneg(res, filtered[31]);
        bvc_pkg::VEL_IK:  num <= num + bvc_pkg::cneg(res, speed_integral[31]);
        bvc_pkg::VEL_DIV_STEP: vel <= bvc_pkg::sat_mag(res, num[65]);
        default: ;
      endcase
    end
  end

  // Output register; drive is the saturated difference of the two terms.
  assign dif = {bal[15], bal} - {vel[15], vel};

  always_ff @(posedge clk) begin
    if (out_load) begin
      balance_term  <= bal;
      velocity_term <= vel;
      if (dif[16] != dif[15]) begin
        drive <= dif[16] ? 16'sh8000 : 16'sh7fff;
      end else begin
        drive <= dif[15:0];
      end
    end
  end

  // An accepted tick always starts the angle wrap in the next cycle.
  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (state == bvc_pkg::ST_WRAP))
    else $error("accepted tick did not start processing");

  // The shared unit only finishes while the sequencer waits for it.
  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    unit_stat.done |-> (state == bvc_pkg::ST_WAIT))
    else $error("unit finished outside of the wait state");

  // The speed integral stays inside its clamp.
  a_integral_bound: assert property (@(posedge clk) disable iff (rst)
    (speed_integral <= INT_LIM) && (speed_integral >= -INT_LIM))
    else $error("speed integral out of range");

  // A finished tick lands in the output register once it is free.
  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    (state == bvc_pkg::ST_DONE && !(out_valid && out_stall)) |=> out_valid)
    else $error("finished result was not presented");

endmodule

`default_nettype wire

FILE: rtl/core/bvc_muldiv.sv
// Bit-serial unsigned multiplier and restoring divider shared by the controller.
`default_nettype none

module bvc_muldiv (
  input  logic                   clk,
  input  logic                   rst,
  input  bvc_pkg::unit_req_t     req,
  input  logic [65:0]            a,
  input  logic [47:0]            b,
  output bvc_pkg::unit_stat_t    stat,
  output logic [65:0]            result
);

  logic                      busy;
  logic                      done;
  bvc_pkg::unit_op_t         op_r;
  logic [bvc_pkg::CNT_W-1:0] cnt;
  logic [65:0]               acc;
  logic [65:0]               opa;
  logic [47:0]               opb;
  logic [47:0]               rem;
  logic [48:0]               rem_sh;
  logic [48:0]               diff;
  logic                      fits;
  logic                      last;

  assign rem_sh = {rem, opa[65]};
  assign diff   = rem_sh - {1'b0, opb};
  assign fits   = !diff[48];
  assign last   = (op_r == bvc_pkg::OP_MUL) ?
                  (cnt == bvc_pkg::CNT_W'(bvc_pkg::MUL_BITS - 1)) :
                  (cnt == bvc_pkg::CNT_W'(bvc_pkg::OP_W - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && last) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // One multiplier bit or one quotient bit per cycle.
  always_ff @(posedge clk) begin
    if (req.start) begin
      op_r <= req.op;
      cnt  <= '0;
      acc  <= '0;
      opa  <= a;
      opb  <= b;
      rem  <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (op_r == bvc_pkg::OP_MUL) begin
        if (opb[0]) begin
          acc <= acc + opa;
        end
        opa <= {opa[64:0], 1'b0};
        opb <= {1'b0, opb[47:1]};
      end else begin
        rem <= fits ? diff[47:0] : rem_sh[47:0];
        opa <= {opa[64:0], fits};
      end
    end
  end

  assign stat   = '{busy: busy, done: done};
  assign result = (op_r == bvc_pkg::OP_MUL) ? acc : opa;

endmodule

`default_nettype wire
